FILE: src/pbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbb_pkg: shared types and constants for the 4x4 pixel binning block
// Field widths, register codes and the line store control word.
// ----------------------------------------------------------------------------
package pbb_pkg;

  localparam int DEF_MAX_BW   = 256;
  localparam int DEF_MAX_BH   = 256;

  localparam int BIN_LOG      = 2;
  localparam int PIX_W        = 16;
  localparam int ROW_SUM_W    = 18;
  localparam int SUM_W        = 20;
  localparam int BRIGHT_W     = 37;
  localparam int FB_W         = 36;
  localparam int COORD_W      = 8;
  localparam int CFG_W        = 9;
  localparam int APB_DW       = 32;
  localparam int APB_AW       = 3;
  localparam int CELL_GRP     = 16;

  localparam logic [CFG_W-1:0] SIZE_RESET = 9'd64;

  localparam logic [BIN_LOG-1:0] BLK_FIRST = 2'd0;
  localparam logic [BIN_LOG-1:0] BLK_LAST  = 2'd3;

  typedef enum logic {
    REG_BIN_WIDTH  = 1'b0,
    REG_BIN_HEIGHT = 1'b1
  } reg_idx_t;

  // Control word from the position logic to the line store.
  typedef struct packed {
    logic accept;       // a pixel word is taken this cycle
    logic wrap;         // position moved to a new row because the width shrank
    logic block_start;  // first pixel of a 4-wide block in this row
    logic block_end;    // last pixel of a 4-wide block in this row
    logic row_end;      // last pixel of the pixel row
  } pbb_ls_ctl_t;

endpackage

FILE: src/pbb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbb_cell: one column cell of the binning line store
// Holds the partial column sum of one binned column and the column token,
// which it hands to its right neighbor when a block is finished.
// ----------------------------------------------------------------------------
module pbb_cell #(
  parameter logic HEAD = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pbb_pkg::pbb_ls_ctl_t          ctl,
  input  logic                          prev_tok,
  input  logic [pbb_pkg::SUM_W-1:0]     wdata,
  output logic                          eff_tok,
  output logic [pbb_pkg::SUM_W-1:0]     rd_data
);
  import pbb_pkg::*;

  logic             tok_r, tok_nxt;
  logic [SUM_W-1:0] val_r, val_nxt;

  // A row wrap caused by a narrower width puts the token back at the head.
  assign eff_tok = ctl.wrap ? HEAD : tok_r;
  assign rd_data = eff_tok ? val_r : '0;

  always_comb begin
    tok_nxt = tok_r;
    val_nxt = val_r;
    if (ctl.accept) begin
      if (ctl.block_end) begin
        tok_nxt = ctl.row_end ? HEAD : prev_tok;
        if (eff_tok) begin
          val_nxt = wdata;
        end
      end else begin
        tok_nxt = eff_tok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= HEAD;
      val_r <= '0;
    end else begin
      tok_r <= tok_nxt;
      val_r <= val_nxt;
    end
  end

endmodule

FILE: src/pbb_line.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbb_line: line store built as a row of column cells
// The column token walks along the cells; the selected cell's sum is
// fetched through a two-stage registered OR tree while a block streams in.
// ----------------------------------------------------------------------------
module pbb_line #(
  parameter int MAX_CELLS = pbb_pkg::DEF_MAX_BW
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pbb_pkg::pbb_ls_ctl_t          ctl,
  input  logic [pbb_pkg::SUM_W-1:0]     wdata,
  output logic [pbb_pkg::SUM_W-1:0]     pf_data
);
  import pbb_pkg::*;

  localparam int NGRP = (MAX_CELLS + CELL_GRP - 1) / CELL_GRP;

  logic [MAX_CELLS-1:0] eff;
  logic [SUM_W-1:0]     rd [MAX_CELLS];
  logic [SUM_W-1:0]     grp_r   [NGRP];
  logic [SUM_W-1:0]     grp_nxt [NGRP];
  logic [NGRP-1:0]      grp_hit;
  logic [SUM_W-1:0]     pf_r, pf_nxt;

  for (genvar i = 0; i < MAX_CELLS; i++) begin : g_cell
    pbb_cell #(
      .HEAD (i == 0 ? 1'b1 : 1'b0)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .prev_tok ((i == 0) ? 1'b0 : eff[(i == 0) ? 0 : i - 1]),
      .wdata    (wdata),
      .eff_tok  (eff[i]),
      .rd_data  (rd[i])
    );
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < CELL_GRP; k++) begin
        if (g * CELL_GRP + k < MAX_CELLS) begin
          grp_nxt[g] = grp_nxt[g] | rd[g * CELL_GRP + k];
        end
      end
    end
  end

  always_comb begin
    pf_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      pf_nxt = pf_nxt | grp_r[g];
      grp_hit[g] = |grp_r[g];
    end
  end

  // The group registers are captured on the first pixel of a block; the
  // sum is needed three words later at the earliest.
  always_ff @(posedge clk) begin
    if (ctl.accept && ctl.block_start) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
    pf_r <= pf_nxt;
  end

  assign pf_data = pf_r;

`ifndef SYNTHESIS
  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(eff))
    else $error("column token is not one-hot");

  a_row_end_head: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.accept && ctl.block_end && ctl.row_end) |=> eff[0])
    else $error("column token did not return to the first cell");

  a_one_group: assert property (@(posedge clk) disable iff (!rst_n)
    $past(ctl.accept && ctl.block_start) |-> $onehot0(grp_hit))
    else $error("prefetch picked up more than one group");
`endif

endmodule

FILE: src/pixel_bin_4x4_with_brightness.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_bin_4x4_with_brightness: 4x4 pixel binning with frame brightness
// Sums each 4x4 block of a raster frame and adds up the whole frame.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock unless stalled and gives the sum of
// a 4x4 block one register stage after the block's bottom-right pixel; the
// brightness of the frame comes with its last block. The frame is four times
// the binned width by four times the binned height; sizes of 0 act as 1 and
// sizes above the maximum act as the maximum. The column sums live in a row
// of cells, one per binned column, cleared by reset with no sweep; the sum of
// a column cell is fetched while the block's first three pixels of a row
// arrive. A result word waiting on out_stall holds off only a pixel that
// would complete another block.
// ----------------------------------------------------------------------------
module pixel_bin_4x4_with_brightness #(
  parameter int MAX_BINNED_WIDTH  = pbb_pkg::DEF_MAX_BW,
  parameter int MAX_BINNED_HEIGHT = pbb_pkg::DEF_MAX_BH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // APB configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pbb_pkg::APB_AW-1:0]     paddr,
  input  logic [pbb_pkg::APB_DW-1:0]     pwdata,
  output logic [pbb_pkg::APB_DW-1:0]     prdata,
  output logic                           pready,
  // pixel input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pbb_pkg::PIX_W-1:0]      in_pixel,
  // binned output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pbb_pkg::SUM_W-1:0]      out_bin_sum,
  output logic [pbb_pkg::COORD_W-1:0]    out_bin_column,
  output logic [pbb_pkg::COORD_W-1:0]    out_bin_row,
  output logic [pbb_pkg::FB_W-1:0]       out_frame_brightness,
  output logic                           out_frame_done
);
  import pbb_pkg::*;

  localparam int WW  = $clog2(MAX_BINNED_WIDTH + 1);
  localparam int HW  = $clog2(MAX_BINNED_HEIGHT + 1);
  localparam int CW  = $clog2(4 * MAX_BINNED_WIDTH);
  localparam int RW  = $clog2(4 * MAX_BINNED_HEIGHT);
  localparam int FWW = WW + BIN_LOG;
  localparam int FHW = HW + BIN_LOG;
  localparam int CMW = (WW > CFG_W) ? WW : CFG_W;
  localparam int CMH = (HW > CFG_W) ? HW : CFG_W;

  // configuration
  logic [CFG_W-1:0] bw_r, bw_nxt, bh_r, bh_nxt;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;
  logic [CMW-1:0]   bw_ext;
  logic [CMH-1:0]   bh_ext;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [FWW-1:0]   full_w;
  logic [FHW-1:0]   full_h;

  // position and sums
  logic [CW-1:0]        col_r, col_nxt, col_n;
  logic [RW-1:0]        row_r, row_nxt, row_n;
  logic [FHW-1:0]       row_t;
  logic                 wrap_c, last_col, last_row;
  logic                 blk_start, blk_end, res_pos;
  logic [ROW_SUM_W-1:0] rps_r, rps_nxt;
  logic [SUM_W-1:0]     colsum, pf_data;
  logic [BRIGHT_W-1:0]  bright_r, bright_nxt, bright_sum;
  logic                 acc, res_acc, frame_end;
  pbb_ls_ctl_t          ls_ctl;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]     o_sum_r;
  logic [COORD_W-1:0]   o_col_r, o_row_r;
  logic [FB_W-1:0]      o_fb_r;
  logic                 o_done_r;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[BIN_LOG]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    bw_nxt = bw_r;
    bh_nxt = bh_r;
    prdata = '0;
    unique case (cfg_idx)
      REG_BIN_WIDTH: begin
        prdata = APB_DW'(bw_r);
        if (cfg_wr) begin
          bw_nxt = pwdata[CFG_W-1:0];
        end
      end
      REG_BIN_HEIGHT: begin
        prdata = APB_DW'(bh_r);
        if (cfg_wr) begin
          bh_nxt = pwdata[CFG_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign bw_ext = CMW'(bw_r);
  assign bh_ext = CMH'(bh_r);

  always_comb begin
    if (bw_ext == '0) begin
      w_eff = WW'(1);
    end else if (bw_ext > CMW'(MAX_BINNED_WIDTH)) begin
      w_eff = WW'(MAX_BINNED_WIDTH);
    end else begin
      w_eff = bw_ext[WW-1:0];
    end
    if (bh_ext == '0) begin
      h_eff = HW'(1);
    end else if (bh_ext > CMH'(MAX_BINNED_HEIGHT)) begin
      h_eff = HW'(MAX_BINNED_HEIGHT);
    end else begin
      h_eff = bh_ext[HW-1:0];
    end
  end

  assign full_w = {w_eff, {BIN_LOG{1'b0}}};
  assign full_h = {h_eff, {BIN_LOG{1'b0}}};

  // ---------------- position ----------------
  // A size change between words may leave the stored position outside the
  // frame; the word then lands at the start of the next row, or row 0.
  always_comb begin
    wrap_c = FWW'(col_r) >= full_w;
    col_n  = wrap_c ? '0 : col_r;
    row_t  = wrap_c ? FHW'(row_r) + FHW'(1) : FHW'(row_r);
    row_n  = (row_t >= full_h) ? '0 : row_t[RW-1:0];
  end

  assign last_col  = (FWW'(col_n) + FWW'(1)) >= full_w;
  assign last_row  = (FHW'(row_n) + FHW'(1)) >= full_h;
  assign blk_start = col_n[BIN_LOG-1:0] == BLK_FIRST;
  assign blk_end   = col_n[BIN_LOG-1:0] == BLK_LAST;
  assign res_pos   = blk_end && (row_n[BIN_LOG-1:0] == BLK_LAST);

  assign in_stall  = out_valid_r && out_stall && res_pos;
  assign acc       = in_valid && !in_stall;
  assign res_acc   = acc && res_pos;
  assign frame_end = last_col && last_row;

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    bright_sum = bright_r + BRIGHT_W'(in_pixel);
    bright_nxt = bright_r;
    rps_nxt    = blk_start ? ROW_SUM_W'(in_pixel) : rps_r + ROW_SUM_W'(in_pixel);
    if (acc) begin
      bright_nxt = bright_sum;
      if (last_col) begin
        col_nxt = '0;
        if (last_row) begin
          row_nxt    = '0;
          bright_nxt = '0;
        end else begin
          row_nxt = row_n + RW'(1);
        end
      end else begin
        col_nxt = col_n + CW'(1);
        row_nxt = row_n;
      end
    end
  end

  // The first row of a bin row starts the column sum afresh.
  assign colsum = (row_n[BIN_LOG-1:0] == BLK_FIRST) ? SUM_W'(rps_nxt)
                                                     : pf_data + SUM_W'(rps_nxt);

  always_comb begin
    ls_ctl.accept      = acc;
    ls_ctl.wrap        = wrap_c;
    ls_ctl.block_start = blk_start;
    ls_ctl.block_end   = blk_end;
    ls_ctl.row_end     = last_col;
  end

  pbb_line #(
    .MAX_CELLS (MAX_BINNED_WIDTH)
  ) u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ls_ctl),
    .wdata   (colsum),
    .pf_data (pf_data)
  );

  // ---------------- output word ----------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r        <= SIZE_RESET;
      bh_r        <= SIZE_RESET;
      col_r       <= '0;
      row_r       <= '0;
      rps_r       <= '0;
      bright_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bw_r        <= bw_nxt;
      bh_r        <= bh_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      bright_r    <= bright_nxt;
      out_valid_r <= out_valid_nxt;
      if (acc) begin
        rps_r <= rps_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_acc) begin
      o_sum_r  <= colsum;
      o_col_r  <= COORD_W'(col_n[CW-1:BIN_LOG]);
      o_row_r  <= COORD_W'(row_n[RW-1:BIN_LOG]);
      o_fb_r   <= frame_end ? bright_sum[FB_W-1:0] : '0;
      o_done_r <= frame_end;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_bin_sum          = o_sum_r;
  assign out_bin_column       = o_col_r;
  assign out_bin_row          = o_row_r;
  assign out_frame_brightness = o_fb_r;
  assign out_frame_done       = o_done_r;

`ifndef SYNTHESIS
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input held off with no word waiting");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (res_acc && frame_end) |=> (bright_r == '0 && col_r == '0 && row_r == '0))
    else $error("frame state not restarted after the last block");

  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !res_acc) |=> !out_valid_r)
    else $error("taken output word was not retired");
`endif

endmodule

FILE: dv/pixel_bin_4x4_with_brightness_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_bin_4x4_with_brightness_tb: self-checking bench for 4x4 pixel binning
// Streams raw pixel frames of many binned sizes through the block. A bit-true
// model in the bench predicts every block sum, its coordinates and the frame
// brightness, and each word on the output channel is checked against it.
// Both channels idle at random, and sizes change between bursts, often in the
// middle of a frame.
// ----------------------------------------------------------------------------
module pixel_bin_4x4_with_brightness_tb;
  import pbb_pkg::*;

  localparam int MAX_BW = DEF_MAX_BW;
  localparam int MAX_BH = DEF_MAX_BH;
  localparam int SIDE   = 4;

  typedef struct packed {
    logic [SUM_W-1:0]   bin_sum;
    logic [COORD_W-1:0] bin_column;
    logic [COORD_W-1:0] bin_row;
    logic [FB_W-1:0]    frame_brightness;
    logic               frame_done;
  } bin_result_t;

  typedef struct packed {
    logic              set_size;
    logic [CFG_W-1:0]  width;
    logic [CFG_W-1:0]  height;
    logic [PIX_W-1:0]  pixel;
    logic              typed;
    bin_result_t       want;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_pixel;
  logic                 out_valid;
  logic                 out_stall;
  logic [SUM_W-1:0]     out_bin_sum;
  logic [COORD_W-1:0]   out_bin_column;
  logic [COORD_W-1:0]   out_bin_row;
  logic [FB_W-1:0]      out_frame_brightness;
  logic                 out_frame_done;

  // Model state of the binning block.
  logic [CFG_W-1:0]     cfg_width;
  logic [CFG_W-1:0]     cfg_height;
  logic [SUM_W-1:0]     col_acc [MAX_BW];
  logic [ROW_SUM_W-1:0] row_acc;
  logic [BRIGHT_W-1:0]  bright_acc;
  int                   pix_col;
  int                   pix_row;

  bin_result_t          bin_expect_q[$];
  stim_row_t            dir_tab [24];
  bit                   idle_on;
  int                   err_count;
  int                   pixels_sent;
  int                   sums_seen;
  int                   frames_seen;
  int                   size_writes;

  pixel_bin_4x4_with_brightness DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_pixel             (in_pixel),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_bin_sum          (out_bin_sum),
    .out_bin_column       (out_bin_column),
    .out_bin_row          (out_bin_row),
    .out_frame_brightness (out_frame_brightness),
    .out_frame_done       (out_frame_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int clamp_size(input logic [CFG_W-1:0] v, input int max_v);
    if (v == 0) return 1;
    return (int'(v) > max_v) ? max_v : int'(v);
  endfunction

  function automatic void bin_model_reset();
    cfg_width  = SIZE_RESET;
    cfg_height = SIZE_RESET;
    foreach (col_acc[i]) col_acc[i] = '0;
    row_acc    = '0;
    bright_acc = '0;
    pix_col    = 0;
    pix_row    = 0;
  endfunction

  // Advances the model by one pixel; returns 1 when the pixel completes a block.
  function automatic bit bin_predict(input logic [PIX_W-1:0] px, output bin_result_t res);
    int fw, fh, c, r, bc;
    logic [SUM_W-1:0] colsum;
    bit hit;
    hit = 1'b0;
    res = '0;
    fw  = SIDE * clamp_size(cfg_width, MAX_BW);
    fh  = SIDE * clamp_size(cfg_height, MAX_BH);
    // A size change can leave the position outside the frame.
    if (pix_col >= fw) begin
      pix_col = 0;
      pix_row++;
    end
    if (pix_row >= fh) pix_row = 0;
    c  = pix_col;
    r  = pix_row;
    bc = c / SIDE;
    bright_acc = bright_acc + px;
    if (c % SIDE == 0) row_acc = px;
    else row_acc = row_acc + px;
    if (c % SIDE == SIDE - 1) begin
      // The top row of a bin row overwrites the stale column sum.
      colsum = (r % SIDE == 0) ? SUM_W'(row_acc) : col_acc[bc] + SUM_W'(row_acc);
      col_acc[bc] = colsum;
      if (r % SIDE == SIDE - 1) begin
        res.bin_sum    = colsum;
        res.bin_column = COORD_W'(bc);
        res.bin_row    = COORD_W'(r / SIDE);
        if (c == fw - 1 && r == fh - 1) begin
          res.frame_brightness = bright_acc[FB_W-1:0];
          res.frame_done       = 1'b1;
        end
        hit = 1'b1;
      end
    end
    if (c + 1 >= fw) begin
      pix_col = 0;
      if (r + 1 >= fh) begin
        pix_row    = 0;
        bright_acc = '0;
      end else begin
        pix_row = r + 1;
      end
    end else begin
      pix_col = c + 1;
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    err_count++;
    // Keep the log readable when a design is badly off.
    if (err_count <= 40)
      $display("ERROR %0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
  endtask

  // psel stays high between the two writes of a size setting.
  task automatic apb_write(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {idx, 2'b00};
    pwdata <= APB_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    if (idx == REG_BIN_WIDTH) cfg_width = val;
    else cfg_height = val;
    size_writes++;
  endtask

  task automatic set_bin_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    apb_write(REG_BIN_WIDTH, w);
    apb_write(REG_BIN_HEIGHT, h);
    psel   <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits until every predicted sum is out, then lets the pipeline settle.
  task automatic drain_results(input int settle);
    while (bin_expect_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed,
                            input bin_result_t typed_res);
    int gap;
    bit hit;
    bin_result_t res;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hit = bin_predict(px, res);
    if (typed) bin_expect_q.push_back(typed_res);
    else if (hit) bin_expect_q.push_back(res);
    pixels_sent++;
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '1;
    if (pick == 1) return '0;
    return PIX_W'($urandom_range(0, 65535));
  endfunction

  task automatic run_burst(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input int count);
    bin_result_t none;
    none = '0;
    in_valid <= 1'b0;
    drain_results(4);
    set_bin_size(w, h);
    idle_on = ($urandom_range(0, 3) != 0);
    repeat (count) send_pixel(rand_pixel(), 1'b0, none);
  endtask

  // Output side: random stall after each accepted word, checked in order.
  initial begin
    int hold;
    bin_result_t want;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (bin_expect_q.size() == 0) begin
          report_mismatch("unexpected word, bin_sum", 0, out_bin_sum);
        end else begin
          want = bin_expect_q.pop_front();
          if (out_bin_sum !== want.bin_sum)
            report_mismatch("bin_sum", want.bin_sum, out_bin_sum);
          if (out_bin_column !== want.bin_column)
            report_mismatch("bin_column", want.bin_column, out_bin_column);
          if (out_bin_row !== want.bin_row)
            report_mismatch("bin_row", want.bin_row, out_bin_row);
          if (out_frame_brightness !== want.frame_brightness)
            report_mismatch("frame_brightness", want.frame_brightness,
                            out_frame_brightness);
          if (out_frame_done !== want.frame_done)
            report_mismatch("frame_done", want.frame_done, out_frame_done);
          sums_seen++;
          if (want.frame_done) frames_seen++;
        end
        hold = idle_on ? $urandom_range(0, 3) : 0;
      end else if (hold > 0) begin
        hold--;
      end
      out_stall <= (hold > 0);
    end
  end

  initial begin
    int k, n, frame, pick;
    logic [CFG_W-1:0] w_val, h_val;
    logic [PIX_W-1:0] edge_px [8];
    rst_n    <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    in_valid <= 1'b0;
    in_pixel <= '0;
    idle_on     = 1'b1;
    err_count   = 0;
    pixels_sent = 0;
    sums_seen   = 0;
    frames_seen = 0;
    size_writes = 0;
    bin_model_reset();

    // Directed rows: a 1x1 frame of full-scale pixels, then sizes of zero and
    // above the maximum with bit patterns that toggle every pixel bit.
    edge_px = '{16'h0000, 16'hAAAA, 16'h5555, 16'h8000,
                16'h0001, 16'h7FFF, 16'hFFFE, 16'h1234};
    for (k = 0; k < 24; k++) dir_tab[k] = '0;
    for (k = 0; k < 16; k++) dir_tab[k].pixel = 16'hFFFF;
    dir_tab[0].set_size = 1'b1;
    dir_tab[0].width    = 9'd1;
    dir_tab[0].height   = 9'd1;
    dir_tab[15].typed   = 1'b1;
    dir_tab[15].want    = '{bin_sum: 20'd1048560, bin_column: 8'd0, bin_row: 8'd0,
                            frame_brightness: 36'd1048560, frame_done: 1'b1};
    dir_tab[16].set_size = 1'b1;
    dir_tab[16].width    = 9'd0;
    dir_tab[16].height   = 9'd511;
    for (k = 0; k < 8; k++) dir_tab[16 + k].pixel = edge_px[k];

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].set_size) begin
        in_valid <= 1'b0;
        drain_results(4);
        set_bin_size(dir_tab[i].width, dir_tab[i].height);
      end
      send_pixel(dir_tab[i].pixel, dir_tab[i].typed, dir_tab[i].want);
    end

    // Narrow rows bring the position to the bottom pixel row of a bin row;
    // the widest size then finishes that bin row across every column, so the
    // last column and the end of frame come out without a whole wide frame.
    run_burst(9'd1, 9'd256, SIDE * ((2 * SIDE - 1 - pix_row % SIDE) % SIDE));
    run_burst(9'd256, 9'd1, SIDE * MAX_BW);

    while (pixels_sent < 1950) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        k = $urandom_range(0, 2);
        w_val = (k == 0) ? 9'd256 : (k == 1) ? 9'd257 : 9'd511;
        h_val = CFG_W'($urandom_range(1, 2));
        n = $urandom_range(50, 400);
      end else if (pick == 1) begin
        w_val = 9'd0;
        k = $urandom_range(0, 3);
        h_val = (k == 0) ? 9'd0 : (k == 1) ? 9'd300 : CFG_W'($urandom_range(1, 3));
        n = (k == 1) ? $urandom_range(50, 300) : 16 * clamp_size(h_val, MAX_BH);
      end else if (pick == 2) begin
        w_val = CFG_W'($urandom_range(7, 64));
        h_val = 9'd1;
        n = 16 * int'(w_val);
      end else begin
        w_val = CFG_W'($urandom_range(1, 6));
        h_val = CFG_W'($urandom_range(1, 4));
        frame = 16 * int'(w_val) * int'(h_val);
        n = frame * $urandom_range(1, 2);
        // Now and then stop mid-frame so the next size lands on a stale position.
        if ($urandom_range(0, 3) == 0) n += $urandom_range(1, frame - 1);
      end
      // The last burst is cut short to keep the run near its planned length.
      if (n > 2000 - pixels_sent) n = 2000 - pixels_sent;
      run_burst(w_val, h_val, n);
    end

    in_valid <= 1'b0;
    drain_results(8);
    $display("Run covered %0d pixel words, %0d block sums and %0d complete frames.",
             pixels_sent, sums_seen, frames_seen);
    $display("Sizes went through %0d register writes, from 1x1 to 256 bins each way.",
             size_writes);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
